// File: rtl/assert_macros.svh
// Assertion macros used by the flow table top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition holds at every clock edge
`define AST_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// File: rtl/ftpc_pkg.sv
// Types and constants of the flow table packet counter
package ftpc_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int IDX_W   = 8;   // slot index along the chain, covers up to 256 cells
	localparam int SLOT_W  = 4;
	localparam int KEY_W   = 48;
	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int CNT_W   = 32;
	localparam int STAT_W  = 3;

	typedef enum logic {
		OP_DATA = 1'b0,
		OP_EXIT = 1'b1
	} op_e;

	typedef enum logic [STAT_W-1:0] {
		ST_COUNTED = 3'd0,
		ST_ADDED   = 3'd1,
		ST_FULL    = 3'd2,
		ST_REMOVED = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_e;

	// Lookup token handed from cell to cell
	typedef struct packed {
		logic             tok;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [CNT_W-1:0] count;
		logic             free_seen;
		logic [IDX_W-1:0] free_idx;
	} link_t;

	// New-entry write broadcast to all cells
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} alloc_t;

endpackage

// File: rtl/flow_table_packet_counter_top.sv
// Top level of the flow table packet counter: command port, cell chain, result
//
//  channel  | dir | handshake           | fields
//  ---------+-----+---------------------+-----------------------------------
//  command  | in  | start && !busy      | opcode, client_ip, client_port
//  result   | out | done (one cycle)    | status, slot, count
//
// A transaction walks the cell chain one cell per cycle; busy stays high
// from accept until the transaction leaves the last cell, so the next
// command can be accepted at the earliest while done is high.
// A new entry is written in the cycle the result is registered.
// Reset clears all valid bits at once: the table starts empty, no clearing pass.
// The result cannot be stalled; done is high for exactly one cycle.
`include "assert_macros.svh"

module flow_table_packet_counter_top #(
	parameter int TABLE_ENTRIES = ftpc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [ftpc_pkg::IP_W-1:0]    client_ip,
	input  logic [ftpc_pkg::PORT_W-1:0]  client_port,
	output logic                         done,
	output logic [ftpc_pkg::STAT_W-1:0]  status,
	output logic [ftpc_pkg::SLOT_W-1:0]  slot,
	output logic [ftpc_pkg::CNT_W-1:0]   count
);

	logic                         accept;
	logic                         busy_q;
	logic                         launch_q;
	logic                         done_q;
	logic [ftpc_pkg::KEY_W-1:0]   key_q;
	ftpc_pkg::op_e                op_q;
	ftpc_pkg::status_e            status_q;
	logic [ftpc_pkg::SLOT_W-1:0]  slot_q;
	logic [ftpc_pkg::CNT_W-1:0]   count_q;

	ftpc_pkg::link_t              links [TABLE_ENTRIES+1];
	ftpc_pkg::link_t              last;
	ftpc_pkg::alloc_t             alloc;
	logic [TABLE_ENTRIES:0]       tok_vec;

	ftpc_pkg::status_e            status_d;
	logic [ftpc_pkg::SLOT_W-1:0]  slot_d;
	logic [ftpc_pkg::CNT_W-1:0]   count_d;

	assign accept = start && !busy_q;

	// Command capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			launch_q <= accept;
			done_q   <= last.tok;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last.tok) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {client_ip, client_port};
			op_q  <= ftpc_pkg::op_e'(opcode);
		end
	end

	// Token entering the first cell
	always_comb begin
		links[0]     = '0;
		links[0].tok = launch_q;
	end

	// Cell chain
	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		ftpc_cell #(
			.CELL_IDX(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.key     (key_q),
			.op      (op_q),
			.link_in (links[g]),
			.link_out(links[g+1]),
			.alloc   (alloc)
		);
	end

	for (genvar t = 0; t <= TABLE_ENTRIES; t++) begin : g_tok
		assign tok_vec[t] = links[t].tok;
	end

	assign last = links[TABLE_ENTRIES];

	// Allocate the lowest free slot on a data miss
	assign alloc.en  = last.tok && (op_q == ftpc_pkg::OP_DATA) && !last.hit && last.free_seen;
	assign alloc.idx = last.free_idx;

	// Result decode at the end of the chain
	always_comb begin
		slot_d  = '0;
		count_d = '0;
		if (op_q == ftpc_pkg::OP_EXIT) begin
			if (last.hit) begin
				status_d = ftpc_pkg::ST_REMOVED;
				slot_d   = last.hit_idx[ftpc_pkg::SLOT_W-1:0];
			end else begin
				status_d = ftpc_pkg::ST_UNKNOWN;
			end
		end else if (last.hit) begin
			status_d = ftpc_pkg::ST_COUNTED;
			slot_d   = last.hit_idx[ftpc_pkg::SLOT_W-1:0];
			count_d  = last.count;
		end else if (last.free_seen) begin
			status_d = ftpc_pkg::ST_ADDED;
			slot_d   = last.free_idx[ftpc_pkg::SLOT_W-1:0];
			count_d  = ftpc_pkg::CNT_W'(1);
		end else begin
			status_d = ftpc_pkg::ST_FULL;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (last.tok) begin
			status_q <= status_d;
			slot_q   <= slot_d;
			count_q  <= count_d;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign status = status_q;
	assign slot   = slot_q;
	assign count  = count_q;

	// Checks
	`AST_SAME(a_done_not_busy, done_q, !busy_q, "result shown while still busy")
	`AST_NEXT(a_accept_busy, accept, busy_q && launch_q, "accepted transaction not launched")
	`AST_ALWAYS(a_single_token, $onehot0(tok_vec), "more than one token in the chain")
	`AST_SAME(a_added_count, done_q && status_q == ftpc_pkg::ST_ADDED, count_q == 1,
		"new entry reported with count other than one")

endmodule

// File: rtl/ftpc_cell.sv
// One table slot: entry storage, key compare and token stage
module ftpc_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ftpc_pkg::KEY_W-1:0] key,
	input  ftpc_pkg::op_e              op,
	input  ftpc_pkg::link_t            link_in,
	output ftpc_pkg::link_t            link_out,
	input  ftpc_pkg::alloc_t           alloc
);

	logic                       valid_q;
	logic [ftpc_pkg::KEY_W-1:0] key_q;
	logic [ftpc_pkg::CNT_W-1:0] count_q;
	ftpc_pkg::link_t            link_q;

	logic                       match;
	logic                       free_here;
	logic                       alloc_here;
	logic [ftpc_pkg::CNT_W-1:0] count_inc;
	ftpc_pkg::link_t            link_d;

	// Compare against the token's key; lowest match wins
	assign match      = link_in.tok && !link_in.hit && valid_q && (key_q == key);
	assign free_here  = link_in.tok && !valid_q && !link_in.free_seen;
	assign alloc_here = alloc.en && (alloc.idx == ftpc_pkg::IDX_W'(CELL_IDX));
	assign count_inc  = (count_q == '1) ? count_q : count_q + 1'b1;

	// Next token contents
	always_comb begin
		link_d = link_in;
		if (match) begin
			link_d.hit     = 1'b1;
			link_d.hit_idx = ftpc_pkg::IDX_W'(CELL_IDX);
			link_d.count   = (op == ftpc_pkg::OP_DATA) ? count_inc : '0;
		end
		if (free_here) begin
			link_d.free_seen = 1'b1;
			link_d.free_idx  = ftpc_pkg::IDX_W'(CELL_IDX);
		end
	end

	// Token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q <= link_d;
		end
	end

	assign link_out = link_q;

	// Entry valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (alloc_here) begin
			valid_q <= 1'b1;
		end else if (match && op == ftpc_pkg::OP_EXIT) begin
			valid_q <= 1'b0;
		end
	end

	// Entry key and message count
	always_ff @(posedge clk) begin
		if (alloc_here) begin
			key_q   <= key;
			count_q <= ftpc_pkg::CNT_W'(1);
		end else if (match && op == ftpc_pkg::OP_DATA) begin
			count_q <= count_inc;
		end
	end

endmodule
